>>> sv/tilt_pkg.sv
// shared types, constants and the arctangent table for the tilt angle block
// no dependencies; imported by every module of the block
package tilt_pkg;

    // fraction bits of the internal angle and vector format
    localparam int INT_FRAC = 16;
    // internal angle accumulator width, holds about +-512 degrees at 2^-16 degree
    localparam int ACC_W = 26;
    // width of one arctangent table entry
    localparam int ATAN_W = 22;
    localparam int TAB_LEN = 24;
    localparam int HALF_TURN_DEG = 180;
    localparam int QUARTER_TURN_DEG = 90;

    // fixed output field widths
    localparam int ROLL_W = 16;
    localparam int PITCH_W = 15;
    localparam int OUT_DATA_W = 48;

    // handshake status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // atan(2^-i) in degrees, scaled by 2^16
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] t;
        case (idx)
            5'd0:    t = 22'd2949120;
            5'd1:    t = 22'd1740967;
            5'd2:    t = 22'd919879;
            5'd3:    t = 22'd466945;
            5'd4:    t = 22'd234379;
            5'd5:    t = 22'd117305;
            5'd6:    t = 22'd58666;
            5'd7:    t = 22'd29335;
            5'd8:    t = 22'd14668;
            5'd9:    t = 22'd7334;
            5'd10:   t = 22'd3667;
            5'd11:   t = 22'd1833;
            5'd12:   t = 22'd917;
            5'd13:   t = 22'd458;
            5'd14:   t = 22'd229;
            5'd15:   t = 22'd115;
            5'd16:   t = 22'd57;
            5'd17:   t = 22'd29;
            5'd18:   t = 22'd14;
            5'd19:   t = 22'd7;
            5'd20:   t = 22'd4;
            5'd21:   t = 22'd2;
            5'd22:   t = 22'd1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

>>> sv/tilt_cordic.sv
// vectoring cordic, one micro-rotation per cycle through a shared shift-add unit
// depends on tilt_pkg (arctangent table, accumulator width, status type)
module tilt_cordic
    import tilt_pkg::*;
#(
    parameter int W = 34,
    parameter int STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [W-1:0]     init_x,
    input  logic signed [W-1:0]     init_y,
    output unit_status_t            status,
    output logic signed [ACC_W-1:0] angle
);

    localparam int CW = $clog2(STEPS);

    logic signed [W-1:0]     px_reg, px_next;
    logic signed [W-1:0]     py_reg, py_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [CW-1:0]           count_reg;
    logic                    zero_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic signed [W-1:0]     dx;
    logic signed [W-1:0]     dy;
    logic signed [ACC_W-1:0] t;

    // one micro-rotation towards the x axis
    always_comb
    begin
        dx = py_reg >>> count_reg;
        dy = px_reg >>> count_reg;
        t  = ACC_W'(atan_entry(5'(count_reg)));
        if (!py_reg[W-1])
        begin
            px_next  = px_reg + dx;
            py_next  = py_reg - dy;
            acc_next = acc_reg + t;
        end
        else
        begin
            px_next  = px_reg - dx;
            py_next  = py_reg + dy;
            acc_next = acc_reg - t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CW'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg   <= init_x;
            py_reg   <= init_y;
            acc_reg  <= '0;
            zero_reg <= (init_y == '0);
        end
        else if (busy_reg)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            acc_reg <= acc_next;
        end
    end

    // a vector on the x axis has angle zero, including the zero vector
    assign angle       = zero_reg ? '0 : acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> sv/tilt_isqrt.sv
// bit-serial integer square root of a sum of squares with 16 fraction bits
// depends on tilt_pkg (fraction width, status type)
module tilt_isqrt
    import tilt_pkg::*;
#(
    parameter int SUM_W = 28
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   radicand,
    output unit_status_t       status,
    output logic [(SUM_W+2*INT_FRAC)/2-1:0] root
);

    localparam int RW = SUM_W + 2 * INT_FRAC;
    localparam int QW = RW / 2;
    localparam int CW = $clog2(QW);

    logic [RW-1:0]   n_reg;
    logic [QW+1:0]   rem_reg;
    logic [QW-1:0]   root_reg;
    logic [CW-1:0]   count_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [QW+1:0]   rem_sh;
    logic [QW+1:0]   trial;
    logic [QW+1:0]   diff;
    logic            ge;

    // one result bit per cycle, two radicand bits brought down
    always_comb
    begin
        rem_sh = {rem_reg[QW-1:0], n_reg[RW-1:RW-2]};
        trial  = {root_reg, 2'b01};
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CW'(QW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= {radicand, {(2 * INT_FRAC){1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[RW-3:0], 2'b00};
            rem_reg  <= ge ? diff : rem_sh;
            root_reg <= {root_reg[QW-2:0], ge};
        end
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> sv/tilt_angles_from_acceleration.sv
// top level of the tilt angle block: sequencer, operand folding, rounding, output beat
// depends on tilt_pkg, tilt_cordic and tilt_isqrt
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------------------
//  s_axis    | in        | s_tvalid/s_tready  | tdata: accel_x, accel_y, accel_z; tuser: capture
//  m_axis    | out       | m_tvalid/m_tready  | tdata: roll_angle, pitch_angle, reference_roll
//
// one beat in gives one beat out, after squaring, the bit-serial square root
// (overlapped with the roll cordic pass) and then the pitch cordic pass of CORDIC_STEPS
// s_tready is high only while the sequencer is idle; a finished result sits in the output
// register, so the next beat is taken while it waits, and the sequencer holds its next
// result until the output register is free
// reset clears the sequencer, the output valid and the held reference roll
module tilt_angles_from_acceleration
    import tilt_pkg::*;
#(
    parameter int SAMPLE_BITS = 14,
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // accel_x, accel_y, accel_z, zero fill
    input  logic [(3*SAMPLE_BITS+7)/8*8-1:0]      s_tdata,
    // capture_reference
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // roll_angle, pitch_angle, reference_roll, zero fill
    output logic [OUT_DATA_W-1:0]                 m_tdata
);

    localparam int S     = SAMPLE_BITS;
    localparam int W     = S + INT_FRAC + 4;
    localparam int SUM_W = 2 * S;
    localparam int QW    = (SUM_W + 2 * INT_FRAC) / 2;
    localparam int SH    = INT_FRAC - ANGLE_FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF      = ACC_W'(1) << (SH - 1);
    localparam logic [ACC_W-1:0] LIM_ROLL  = ACC_W'(HALF_TURN_DEG) << ANGLE_FRAC_BITS;
    localparam logic [ACC_W-1:0] LIM_PITCH = ACC_W'(QUARTER_TURN_DEG) << ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] BASE_HALF = ACC_W'(HALF_TURN_DEG) <<< INT_FRAC;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_START,
        ST_ROLL,
        ST_SQRT,
        ST_PITCH,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // sample registers
    logic signed [S-1:0]       x_reg, y_reg, z_reg;
    logic                      cap_reg;
    logic signed [SUM_W-1:0]   sqy_reg, sqz_reg;
    logic signed [ACC_W-1:0]   roll_acc_reg;
    logic [ROLL_W-1:0]         roll_reg;
    logic signed [ACC_W-1:0]   pitch_acc_reg;
    logic [ROLL_W-1:0]         held_ref_reg, held_ref_next;

    // output register
    logic                      m_tvalid_reg;
    logic [ROLL_W-1:0]         out_roll_reg;
    logic [PITCH_W-1:0]        out_pitch_reg;
    logic [ROLL_W-1:0]         out_ref_reg;

    // unit connections
    logic                      cordic_start;
    logic signed [W-1:0]       cordic_x, cordic_y;
    unit_status_t              cordic_status;
    logic signed [ACC_W-1:0]   cordic_angle;
    logic                      sqrt_start;
    logic [SUM_W-1:0]          sqrt_radicand;
    unit_status_t              sqrt_status;
    logic [QW-1:0]             sqrt_root;

    logic                      accept_in;
    logic                      load_out;
    logic signed [W-1:0]       zw, yw, xw;
    logic signed [ACC_W-1:0]   roll_base;
    logic [ACC_W-1:0]          pitch_rounded;

    // round from 2^-16 degree to output steps, half away from zero, then saturate
    function automatic logic [ACC_W-1:0] round_sat(input logic signed [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] lim);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        r   = (mag + HALF) >> SH;
        if (r > lim)
        begin
            r = lim;
        end
        return a[ACC_W-1] ? ACC_W'(-r) : r;
    endfunction

    assign accept_in = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign load_out  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // operands in the internal format, 16 fraction bits
    always_comb
    begin
        zw = W'(z_reg) <<< INT_FRAC;
        yw = W'(y_reg) <<< INT_FRAC;
        xw = W'(x_reg) <<< INT_FRAC;
    end

    // left half-plane folds onto the right one, the half turn comes back as a base angle
    always_comb
    begin
        roll_base = '0;
        if (z_reg[S-1])
        begin
            roll_base = y_reg[S-1] ? -BASE_HALF : BASE_HALF;
        end
    end

    // the shared cordic runs the roll pass first, then the pitch pass
    always_comb
    begin
        cordic_start = 1'b0;
        cordic_x     = zw;
        cordic_y     = yw;
        if (state_reg == ST_START)
        begin
            cordic_start = 1'b1;
            cordic_x     = z_reg[S-1] ? -zw : zw;
            cordic_y     = z_reg[S-1] ? -yw : yw;
        end
        else if (state_reg == ST_SQRT)
        begin
            cordic_start = sqrt_status.done;
            cordic_x     = W'(sqrt_root);
            cordic_y     = xw;
        end
    end

    assign sqrt_start    = (state_reg == ST_START);
    assign sqrt_radicand = SUM_W'(sqy_reg) + SUM_W'(sqz_reg);

    tilt_cordic #(
        .W     (W),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .init_x (cordic_x),
        .init_y (cordic_y),
        .status (cordic_status),
        .angle  (cordic_angle)
    );

    tilt_isqrt #(
        .SUM_W (SUM_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .status   (sqrt_status),
        .root     (sqrt_root)
    );

    assign pitch_rounded = round_sat(pitch_acc_reg, LIM_PITCH);
    assign held_ref_next = cap_reg ? roll_reg : held_ref_reg;

    // sequencer, held reference and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            held_ref_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // a beat taken while the next result loads keeps valid high
            if (m_tvalid_reg && m_tready && !load_out)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_ROLL;
                end
                ST_ROLL:
                begin
                    if (cordic_status.done)
                    begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (sqrt_status.done)
                    begin
                        state_reg <= ST_PITCH;
                    end
                end
                ST_PITCH:
                begin
                    if (cordic_status.done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (load_out)
                    begin
                        state_reg    <= ST_IDLE;
                        held_ref_reg <= held_ref_next;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            x_reg   <= s_tdata[S-1:0];
            y_reg   <= s_tdata[2*S-1:S];
            z_reg   <= s_tdata[3*S-1:2*S];
            cap_reg <= s_tuser[0];
        end
        if (state_reg == ST_SQUARE)
        begin
            sqy_reg <= y_reg * y_reg;
            sqz_reg <= z_reg * z_reg;
        end
        if ((state_reg == ST_ROLL) && cordic_status.done)
        begin
            roll_acc_reg <= roll_base + cordic_angle;
        end
        if (state_reg == ST_SQRT)
        begin
            roll_reg <= ROLL_W'(round_sat(roll_acc_reg, LIM_ROLL));
        end
        if ((state_reg == ST_PITCH) && cordic_status.done)
        begin
            pitch_acc_reg <= cordic_angle;
        end
        if (load_out)
        begin
            out_roll_reg  <= roll_reg;
            out_pitch_reg <= pitch_rounded[PITCH_W-1:0];
            out_ref_reg   <= held_ref_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_ref_reg, out_pitch_reg, out_roll_reg};

    // the sequencer takes nothing new until the current beat is through
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> !s_tready)
        else $error("input taken while an item is in work");

    // a result only appears from the finishing step
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("output valid rose outside the finishing step");

    // the reference roll only moves when a result is loaded
    a_ref_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (held_ref_reg != $past(held_ref_reg)) |-> $past(load_out))
        else $error("reference roll changed without a result");

    // the pitch pass never starts before the square root has finished
    a_pitch_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        (cordic_start && (state_reg == ST_SQRT)) |-> !sqrt_status.busy)
        else $error("pitch pass started on an unfinished magnitude");

endmodule

>>> bench/tb_tilt_angles_from_acceleration.sv
// self-checking bench for tilt_angles_from_acceleration: directed and random samples
// depends on tilt_pkg and the block itself; predicts every output beat on its own
module tb_tilt_angles_from_acceleration;
    import tilt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 14;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS = 16;

    // input beat is three samples packed from the lowest bits, padded to whole bytes
    localparam int IN_DATA_W = (3 * SAMPLE_BITS + 7) / 8 * 8;
    localparam int PAD_W = IN_DATA_W - 3 * SAMPLE_BITS;

    // shift from the internal 2^-16 degree format down to output steps
    localparam int FRAC_SHIFT = INT_FRAC - ANGLE_FRAC_BITS;
    localparam longint HALF_STEP = longint'(1) << (FRAC_SHIFT - 1);

    localparam int MAX_WAIT = 11;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int RANDOM_PHASES = 4;
    // settle time after the last result, so the tail has some room
    localparam int SETTLE_CYCLES = 80;
    // limit on the whole run, sized for 1322 beats with their gaps and stalls
    localparam int CYCLE_LIMIT = 600000;

    // arctangent of 2^-i in degrees at 2^-16 degree resolution
    localparam int ARCTAN_LEN = 24;
    localparam longint ARCTAN_DEG16 [0:ARCTAN_LEN-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // one expected output beat: the roll, pitch and reference fields of m_tdata
    typedef struct packed {
        logic [ROLL_W-1:0]  roll;
        logic [PITCH_W-1:0] pitch;
        logic [ROLL_W-1:0]  ref_roll;
    } angles_t;

    // predicts roll, pitch and the latched reference, and checks output beats in order
    class angle_scoreboard;
        angles_t           expected_angles[$];
        logic [ROLL_W-1:0] held_roll;
        int unsigned       failures;

        function new();
            held_roll = '0;
            failures = 0;
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction

        // vectoring pass, px never negative; angle in 2^-16 degree
        function longint vector_angle(longint px, longint py);
            longint acc;
            longint t;
            longint dx;
            longint dy;
            acc = 0;
            if (py == 0)
                return 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                t = (i < ARCTAN_LEN) ? ARCTAN_DEG16[i] : 0;
                dx = py >>> i;
                dy = px >>> i;
                if (py >= 0)
                begin
                    px = px + dx;
                    py = py - dy;
                    acc = acc + t;
                end
                else
                begin
                    px = px - dx;
                    py = py + dy;
                    acc = acc - t;
                end
            end
            return acc;
        endfunction

        // half away from zero, then clamp to the angle limit
        function longint round_clamp(longint acc, longint limit_deg);
            longint mag;
            longint r;
            longint lim;
            mag = (acc < 0) ? -acc : acc;
            lim = limit_deg << ANGLE_FRAC_BITS;
            r = (mag + HALF_STEP) >>> FRAC_SHIFT;
            if (r > lim)
                r = lim;
            return (acc < 0) ? -r : r;
        endfunction

        // exact integer square root, bit by bit
        function longint unsigned exact_root(longint unsigned n);
            longint unsigned res;
            longint unsigned probe;
            res = 0;
            probe = 64'h4000_0000_0000_0000;
            while (probe > n)
                probe = probe >> 2;
            while (probe != 0)
            begin
                if (n >= res + probe)
                begin
                    n = n - (res + probe);
                    res = (res >> 1) + probe;
                end
                else
                    res = res >> 1;
                probe = probe >> 2;
            end
            return res;
        endfunction

        function void note_sample(sample_t ax, sample_t ay, sample_t az, logic capture);
            longint x;
            longint y;
            longint z;
            longint vx;
            longint vy;
            longint base;
            longint roll;
            longint pitch;
            longint unsigned mag;
            angles_t e;
            x = ax;
            y = ay;
            z = az;
            // roll: fold the left half-plane onto the right, starting from +-180
            vx = z <<< INT_FRAC;
            vy = y <<< INT_FRAC;
            base = 0;
            if (z < 0)
            begin
                base = ((y >= 0) ? HALF_TURN_DEG : -HALF_TURN_DEG) <<< INT_FRAC;
                vx = -vx;
                vy = -vy;
            end
            roll = round_clamp(base + vector_angle(vx, vy), HALF_TURN_DEG);
            // pitch against the magnitude of (y, z), 16 fraction bits
            mag = exact_root(longint'(y * y + z * z) << 32);
            pitch = round_clamp(vector_angle(longint'(mag), x <<< INT_FRAC), QUARTER_TURN_DEG);
            if (capture)
                held_roll = roll[ROLL_W-1:0];
            e.roll = roll[ROLL_W-1:0];
            e.pitch = pitch[PITCH_W-1:0];
            e.ref_roll = held_roll;
            expected_angles.push_back(e);
        endfunction

        function void check_angles(logic [ROLL_W-1:0] roll, logic [PITCH_W-1:0] pitch,
                                   logic [ROLL_W-1:0] ref_roll);
            angles_t e;
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got roll %0d pitch %0d ref %0d",
                         $time, $signed(roll), $signed(pitch), $signed(ref_roll));
                failures++;
                return;
            end
            e = expected_angles.pop_front();
            if (roll !== e.roll)
            begin
                $display("%0t: roll_angle expected %0d, got %0d",
                         $time, $signed(e.roll), $signed(roll));
                failures++;
            end
            if (pitch !== e.pitch)
            begin
                $display("%0t: pitch_angle expected %0d, got %0d",
                         $time, $signed(e.pitch), $signed(pitch));
                failures++;
            end
            if (ref_roll !== e.ref_roll)
            begin
                $display("%0t: reference_roll expected %0d, got %0d",
                         $time, $signed(e.ref_roll), $signed(ref_roll));
                failures++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // accel_x, accel_y, accel_z, zero fill
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // capture_reference
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // roll_angle, pitch_angle, reference_roll, zero fill
    logic [OUT_DATA_W-1:0] m_tdata;

    angle_scoreboard sb;
    // steady modes switch off the random gaps on one side for a whole phase
    bit              tx_steady = 1'b0;
    bit              rx_steady = 1'b0;
    int unsigned     cycle_count = 0;

    tilt_angles_from_acceleration #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // cycles to wait before the next beat; at least a quarter of draws are back to back, all in steady mode
    function automatic int draw_wait(bit steady);
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // axis value: mostly full range, with zeros, tiny values and the rails mixed in
    function automatic sample_t draw_axis();
        int k;
        case ($urandom_range(0, 9))
            0: k = 0;
            1: k = int'($urandom_range(0, 8)) - 4;
            2: k = $urandom_range(0, 1) ? -8192 : 8191;
            default: k = int'($urandom_range(0, 16383)) - 8192;
        endcase
        return sample_t'(k);
    endfunction

    // one input beat; valid stays high across back-to-back beats
    task automatic send_sample(input sample_t x, input sample_t y, input sample_t z,
                               input logic capture);
        int gap;
        gap = draw_wait(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{PAD_W{1'b0}}, z, y, x};
        s_tuser <= capture;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold the sender off until every outstanding beat has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // both handshakes are judged on values from before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_angles(m_tdata[15:0], m_tdata[30:16], m_tdata[46:31]);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata[SAMPLE_BITS-1:0],
                               s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
                               s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS],
                               s_tuser[0]);
        end
    end

    // receiver: a fresh stall before each result beat
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(rx_steady);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // watchdog on the whole run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero vector, with and without capture
        send_sample(14'sd0, 14'sd0, 14'sd0, 1'b0);
        send_sample(14'sd0, 14'sd0, 14'sd0, 1'b1);
        // zero y with negative z gives +180, also latched
        send_sample(14'sd0, 14'sd0, -14'sd5, 1'b0);
        send_sample(14'sd0, 14'sd0, -14'sd8192, 1'b1);
        send_sample(14'sd0, 14'sd0, 14'sd8191, 1'b0);
        // x alone drives pitch into its clamp
        send_sample(14'sd8191, 14'sd0, 14'sd0, 1'b0);
        send_sample(-14'sd8192, 14'sd0, 14'sd0, 1'b1);
        send_sample(14'sd8191, 14'sd0, 14'sd1, 1'b0);
        send_sample(-14'sd8192, 14'sd1, 14'sd0, 1'b0);
        // quarter turns of roll
        send_sample(14'sd0, 14'sd8191, 14'sd0, 1'b0);
        send_sample(14'sd0, -14'sd8192, 14'sd0, 1'b1);
        // just either side of the half turn
        send_sample(14'sd0, -14'sd1, -14'sd8192, 1'b0);
        send_sample(14'sd0, 14'sd1, -14'sd8192, 1'b1);
        // rails on every axis
        send_sample(14'sd8191, 14'sd8191, 14'sd8191, 1'b1);
        send_sample(-14'sd8192, -14'sd8192, -14'sd8192, 1'b0);
        send_sample(-14'sd8192, 14'sd8191, -14'sd8192, 1'b0);
        send_sample(14'sd8191, -14'sd8192, 14'sd8191, 1'b1);
        send_sample(14'sd0, -14'sd8192, -14'sd8192, 1'b0);
        // smallest non-zero vectors
        send_sample(14'sd1, -14'sd1, 14'sd1, 1'b0);
        send_sample(-14'sd1, 14'sd1, -14'sd1, 1'b1);
        send_sample(14'sd100, 14'sd0, 14'sd1, 1'b0);
        send_sample(14'sd5, 14'sd3, 14'sd4, 1'b0);
        drain_results();

        // random phases with different idling on each side
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            tx_steady = (phase == 1) || (phase == 3);
            rx_steady = (phase == 2) || (phase == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(draw_axis(), draw_axis(), draw_axis(),
                            $urandom_range(0, 3) == 0);
            if (phase == 1)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
